/* hw/rtl/unipolar_stepper_move_sequencer_core_assert.svh */
// assertion macros for the unipolar stepper move sequencer
// expects clk and rst_n in the scope of use, no other dependencies
`ifndef UNIPOLAR_STEPPER_MOVE_SEQUENCER_CORE_ASSERT_SVH
`define UNIPOLAR_STEPPER_MOVE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define USMS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define USMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/usms_pkg.sv */
// shared types, constants and the coil pattern table of the stepper move sequencer
// no dependencies
`default_nettype none

package usms_pkg;

    localparam int TIME_W      = 32;
    localparam int STEPS_W     = 24;
    localparam int POS_W       = 32;
    localparam int MIN_W       = 16;
    localparam int MODE_W      = 2;
    localparam int COIL_W      = 4;
    localparam int PHASE_W     = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [MIN_W-1:0] MIN_STEP_RESET = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEP  = 1'b1;

    // step modes
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WAVE = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_LOAD  = 2'd3
    } usms_cmd_t;

    typedef struct packed {
        logic [1:0]               command;
        logic                     turn_clockwise;
        logic [STEPS_W-1:0]       move_steps;
        logic [STEPS_W-1:0]       target_step_us;
        logic signed [POS_W-1:0]  position_value;
    } usms_in_t;

    typedef struct packed {
        logic [COIL_W-1:0]        coil_drive;
        logic                     moving;
        logic [STEPS_W-1:0]       steps_left;
        logic signed [POS_W-1:0]  position;
    } usms_out_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } usms_unit_status_t;

    localparam logic [COIL_W-1:0] HALF_PATTERN [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    // pattern for a 4-bit phase code, off beyond the eight half steps
    function automatic logic [COIL_W-1:0] pattern_of(input logic [3:0] idx);
        return idx[3] ? '0 : HALF_PATTERN[idx[2:0]];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/usms_serial_mul.sv */
// bit-serial shift-add multiplier, msb of the multiplier first, saturating at 32 bits
// depends on usms_pkg
`default_nettype none

module usms_serial_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [usms_pkg::STEPS_W-1:0] multiplicand,
    input  logic [usms_pkg::STEPS_W-1:0] multiplier,
    output logic [usms_pkg::TIME_W-1:0]  product,
    output usms_pkg::usms_unit_status_t  status
);
    import usms_pkg::*;

    localparam int CNT_W = $clog2(STEPS_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS_W - 1);

    logic [TIME_W-1:0]  acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic [STEPS_W-1:0] mcand_reg, mcand_next;
    logic [STEPS_W-1:0] mplier_reg, mplier_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TIME_W+1:0]  sum;

    // acc * 2 + (bit ? multiplicand : 0)
    assign sum = {1'b0, acc_reg, 1'b0}
               + {(TIME_W+2-STEPS_W)'(0), mplier_reg[STEPS_W-1] ? mcand_reg : '0};

    always_comb
    begin
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            sat_next    = 1'b0;
            mcand_next  = multiplicand;
            mplier_next = multiplier;
            count_next  = CNT_LAST;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next    = sum[TIME_W-1:0];
            sat_next    = sat_reg | (sum[TIME_W+1:TIME_W] != 2'b00);
            mplier_next = {mplier_reg[STEPS_W-2:0], 1'b0};
            count_next  = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sat_reg    <= sat_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product     = sat_reg ? '1 : acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/usms_serial_div.sv */
// restoring divider, one quotient bit per cycle, 32-bit dividend by 24-bit divisor
// depends on usms_pkg
`default_nettype none

module usms_serial_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [usms_pkg::TIME_W-1:0]  dividend,
    input  logic [usms_pkg::STEPS_W-1:0] divisor,
    output logic [usms_pkg::TIME_W-1:0]  quotient,
    output usms_pkg::usms_unit_status_t  status
);
    import usms_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

    logic [TIME_W-1:0]  quo_reg, quo_next;
    logic [STEPS_W-1:0] rem_reg, rem_next;
    logic [STEPS_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEPS_W:0]   trial;
    logic [STEPS_W:0]   diff;
    logic               fits;

    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            den_next   = divisor;
            count_next = CNT_LAST;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so it fits in 24 bits
            rem_next   = fits ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
            quo_next   = {quo_reg[TIME_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/unipolar_stepper_move_sequencer_core.sv */
// unipolar stepper move sequencer: stop, load and start with zero steps go from idle straight
// to the finish state, a tick without a step passes through the check state, a start runs
// the 24-bit serial multiply, and a tick that steps runs the 32-bit serial divide and the apply state
// one command in flight at a time: the next is taken once the last result is registered, which result stalls can delay
// async active-low reset: coils off, time, move state and position zero, half step, 1000 us
`default_nettype none

module unipolar_stepper_move_sequencer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [usms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [usms_pkg::CFG_DATA_W-1:0]  cfg_data,
    // command channel
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  usms_pkg::usms_in_t               cmd_data,
    // result channel
    output logic                             res_valid,
    input  logic                             res_ready,
    output usms_pkg::usms_out_t              res_data
);
    import usms_pkg::*;

`include "unipolar_stepper_move_sequencer_core_assert.svh"

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_MUL    = 6'b000100,
        S_DIV    = 6'b001000,
        S_APPLY  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t              state_reg, state_next;

    // configuration
    logic [MODE_W-1:0]   step_mode_reg, step_mode_next;
    logic [MIN_W-1:0]    min_step_reg, min_step_next;

    // move state
    logic [TIME_W-1:0]   time_now_reg, time_now_next;
    logic [TIME_W-1:0]   start_time_reg, start_time_next;
    logic [TIME_W-1:0]   duration_reg, duration_next;
    logic [TIME_W-1:0]   next_step_reg, next_step_next;
    logic [STEPS_W-1:0]  remaining_steps_reg, remaining_steps_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                dir_cw_reg, dir_cw_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [COIL_W-1:0]   coil_reg, coil_next;

    // result register, parts the two channels
    logic                res_valid_reg, res_valid_next;
    usms_out_t           res_data_reg, res_data_next;

    // serial units
    logic                mul_start;
    logic                div_start;
    logic [STEPS_W-1:0]  per_step;
    logic [TIME_W-1:0]   mul_product;
    logic [TIME_W-1:0]   div_quotient;
    usms_unit_status_t   mul_status;
    usms_unit_status_t   div_status;

    // step arithmetic
    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W:0]     time_diff;
    logic [TIME_W-1:0]   left_time;
    logic [TIME_W-1:0]   min_step_ext;
    logic [TIME_W-1:0]   delay;
    logic                step_due;
    logic [PHASE_W-1:0]  last_phase;
    logic                moving;

    // terms for the checks at the end
    logic                units_idle;
    logic                in_apply;
    logic                finish_go;
    logic [STEPS_W-1:0]  steps_dec;

    assign cmd_ready = (state_reg == S_IDLE);

    // requested period with the configured floor, latched by the multiplier
    assign per_step = (cmd_data.target_step_us < {(STEPS_W-MIN_W)'(0), min_step_reg})
                    ? {(STEPS_W-MIN_W)'(0), min_step_reg} : cmd_data.target_step_us;

    // time still left in the move, zero once the move duration has run out
    assign elapsed   = time_now_reg - start_time_reg;
    assign time_diff = {1'b0, duration_reg} - {1'b0, elapsed};
    assign left_time = time_diff[TIME_W] ? '0 : time_diff[TIME_W-1:0];

    // deadline reached and steps remain
    assign step_due = !(time_now_reg < next_step_reg) && (remaining_steps_reg != '0);

    // step period floors at min_step_us
    assign min_step_ext = {(TIME_W-MIN_W)'(0), min_step_reg};
    assign delay        = (div_quotient < min_step_ext) ? min_step_ext : div_quotient;

    assign last_phase = (step_mode_reg == MODE_HALF) ? PHASE_W'(7) : PHASE_W'(3);
    assign moving     = (remaining_steps_reg != '0) || (time_now_reg < next_step_reg);

    usms_serial_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (per_step),
        .multiplier   (cmd_data.move_steps),
        .product      (mul_product),
        .status       (mul_status)
    );

    usms_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_time),
        .divisor  (remaining_steps_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_comb
    begin
        state_next           = state_reg;
        step_mode_next       = step_mode_reg;
        min_step_next        = min_step_reg;
        time_now_next        = time_now_reg;
        start_time_next      = start_time_reg;
        duration_next        = duration_reg;
        next_step_next       = next_step_reg;
        remaining_steps_next = remaining_steps_reg;
        phase_next           = phase_reg;
        dir_cw_next          = dir_cw_reg;
        position_next        = position_reg;
        coil_next            = coil_reg;
        res_valid_next       = res_valid_reg;
        res_data_next        = res_data_reg;
        mul_start            = 1'b0;
        div_start            = 1'b0;

        // configuration writes are for the user to make only while idle; the block does not enforce it
        if (cfg_write)
        begin
            case (cfg_index)
                REG_STEP_MODE: step_mode_next = cfg_data[MODE_W-1:0];
                REG_MIN_STEP:  min_step_next  = cfg_data[MIN_W-1:0];
                default:       ;
            endcase
        end

        // result taken downstream
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_data.command)
                        CMD_TICK:
                        begin
                            time_now_next = time_now_reg + 1'b1;
                            state_next    = S_CHECK;
                        end
                        CMD_START:
                        begin
                            if (cmd_data.move_steps != '0)
                            begin
                                dir_cw_next          = cmd_data.turn_clockwise;
                                remaining_steps_next = cmd_data.move_steps;
                                start_time_next      = time_now_reg;
                                mul_start            = 1'b1;
                                state_next           = S_MUL;
                            end
                            else
                            begin
                                // zero steps acts as stop
                                remaining_steps_next = '0;
                                duration_next        = '0;
                                next_step_next       = '0;
                                state_next           = S_FINISH;
                            end
                        end
                        CMD_STOP:
                        begin
                            // coils keep their last pattern
                            remaining_steps_next = '0;
                            duration_next        = '0;
                            next_step_next       = '0;
                            state_next           = S_FINISH;
                        end
                        CMD_LOAD:
                        begin
                            position_next = cmd_data.position_value;
                            state_next    = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if (step_due)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_MUL:
            begin
                // duration saturates at all ones inside the multiplier
                if (mul_status.done)
                begin
                    duration_next = mul_product;
                    state_next    = S_FINISH;
                end
            end

            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                next_step_next = time_now_reg + delay;

                // unused mode three leaves the coils alone
                case (step_mode_reg)
                    MODE_HALF: coil_next = pattern_of({1'b0, phase_reg});
                    MODE_FULL: coil_next = pattern_of({phase_reg, 1'b1});
                    MODE_WAVE: coil_next = pattern_of({phase_reg, 1'b0});
                    default:   coil_next = coil_reg;
                endcase

                // going clockwise, a phase at or past the last one wraps to zero
                if (dir_cw_reg)
                begin
                    phase_next    = (phase_reg < last_phase) ? phase_reg + 1'b1 : '0;
                    position_next = position_reg + 1'b1;
                end
                else
                begin
                    phase_next    = (phase_reg != '0) ? phase_reg - 1'b1 : last_phase;
                    position_next = position_reg - 1'b1;
                end

                remaining_steps_next = remaining_steps_reg - 1'b1;
                state_next           = S_FINISH;
            end

            S_FINISH:
            begin
                // wait for the result register to free up
                if (!res_valid_reg || res_ready)
                begin
                    res_data_next.coil_drive = coil_reg;
                    res_data_next.moving     = moving;
                    res_data_next.steps_left = remaining_steps_reg;
                    res_data_next.position   = position_reg;
                    res_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            step_mode_reg       <= MODE_HALF;
            min_step_reg        <= MIN_STEP_RESET;
            time_now_reg        <= '0;
            start_time_reg      <= '0;
            duration_reg        <= '0;
            next_step_reg       <= '0;
            remaining_steps_reg <= '0;
            phase_reg           <= '0;
            dir_cw_reg          <= 1'b0;
            position_reg        <= '0;
            coil_reg            <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            step_mode_reg       <= step_mode_next;
            min_step_reg        <= min_step_next;
            time_now_reg        <= time_now_next;
            start_time_reg      <= start_time_next;
            duration_reg        <= duration_next;
            next_step_reg       <= next_step_next;
            remaining_steps_reg <= remaining_steps_next;
            phase_reg           <= phase_next;
            dir_cw_reg          <= dir_cw_next;
            position_reg        <= position_next;
            coil_reg            <= coil_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign units_idle = !div_status.busy && !mul_status.busy;
    assign in_apply   = (state_reg == S_APPLY);
    assign finish_go  = (state_reg == S_FINISH) && (!res_valid_reg || res_ready);
    assign steps_dec  = remaining_steps_reg - 1'b1;

    // the two serial units never run together
    `USMS_ASSERT_HOLDS(a_units_exclusive, div_status.busy, !mul_status.busy, "mul and div overlap")

    // a new command is only taken with both serial units at rest
    `USMS_ASSERT_HOLDS(a_ready_units_idle, cmd_ready, units_idle, "ready while a unit is busy")

    // every applied step takes exactly one off the step count
    `USMS_ASSERT_NEXT(a_step_counts_down, in_apply, remaining_steps_reg == $past(steps_dec), "no count")

    // a finished transaction shows up as a valid result and frees the command side
    `USMS_ASSERT_NEXT(a_finish_delivers, finish_go, res_valid && cmd_ready, "result not delivered")

endmodule

`default_nettype wire

/* verif/usms_motion_checker.sv */
// checker for the stepper move sequencer: watches the register port and both channels,
// predicts every result transaction and compares it field by field; needs usms_pkg only
`default_nettype none

module usms_motion_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [usms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [usms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             cmd_valid,
    input  logic                             cmd_ready,
    input  usms_pkg::usms_in_t               cmd_data,
    input  logic                             res_valid,
    input  logic                             res_ready,
    input  usms_pkg::usms_out_t              res_data,
    output int                               mismatch_total,
    output int                               open_expectations
);
    timeunit 1ns;
    timeprecision 1ps;
    import usms_pkg::*;

    // shadow of the block's registers and move state
    logic [MODE_W-1:0]  mode_q;
    logic [MIN_W-1:0]   min_step_q;
    logic [TIME_W-1:0]  now_us;
    logic [TIME_W-1:0]  move_begin_us;
    logic [TIME_W-1:0]  move_span_us;
    logic [TIME_W-1:0]  deadline_us;
    logic [STEPS_W-1:0] steps_pending;
    logic [PHASE_W-1:0] phase_q;
    logic               clockwise_q;
    logic [POS_W-1:0]   position_q;
    logic [COIL_W-1:0]  coils_q;

    usms_out_t coil_status_queue[$];
    usms_out_t oldest;
    usms_out_t predicted;
    int        errors;

    function automatic logic [COIL_W-1:0] coil_pattern(input logic [3:0] code);
        case (code)
            4'd0:    return 4'h1;
            4'd1:    return 4'h3;
            4'd2:    return 4'h2;
            4'd3:    return 4'h6;
            4'd4:    return 4'h4;
            4'd5:    return 4'hC;
            4'd6:    return 4'h8;
            4'd7:    return 4'h9;
            default: return 4'h0;
        endcase
    endfunction

    // apply one command to the shadow state, return the status it produces
    task automatic advance_sequencer(input usms_in_t c, output usms_out_t r);
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  left_us;
        logic [TIME_W-1:0]  delay_us;
        logic [3:0]         phase_count;
        logic [STEPS_W-1:0] per_step;
        logic [47:0]        span;
        if (c.command == CMD_TICK) begin
            now_us = now_us + 1;
            if (!(now_us < deadline_us) && steps_pending != 0) begin
                elapsed  = now_us - move_begin_us;
                left_us  = (elapsed < move_span_us) ? move_span_us - elapsed : '0;
                delay_us = left_us / {8'd0, steps_pending};
                if (delay_us < {16'd0, min_step_q})
                    delay_us = {16'd0, min_step_q};
                deadline_us = now_us + delay_us;
                case (mode_q)
                    MODE_HALF: coils_q = coil_pattern({1'b0, phase_q});
                    MODE_FULL: coils_q = coil_pattern({phase_q, 1'b1});
                    MODE_WAVE: coils_q = coil_pattern({phase_q, 1'b0});
                    default:   ;
                endcase
                phase_count = (mode_q == MODE_HALF) ? 4'd8 : 4'd4;
                if (clockwise_q)
                    phase_q = ({1'b0, phase_q} < phase_count - 4'd1) ? phase_q + 3'd1 : 3'd0;
                else
                    phase_q = (phase_q != 0) ? phase_q - 3'd1 : 3'(phase_count - 4'd1);
                steps_pending = steps_pending - 1'b1;
                position_q    = clockwise_q ? position_q + 1 : position_q - 1;
            end
        end else if (c.command == CMD_START && c.move_steps != 0) begin
            per_step      = (c.target_step_us < {8'd0, min_step_q}) ? {8'd0, min_step_q}
                                                                    : c.target_step_us;
            span          = {24'd0, c.move_steps} * {24'd0, per_step};
            clockwise_q   = c.turn_clockwise;
            steps_pending = c.move_steps;
            move_span_us  = (span > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
            move_begin_us = now_us;
        end else if (c.command == CMD_START || c.command == CMD_STOP) begin
            steps_pending = '0;
            move_span_us  = '0;
            deadline_us   = '0;
        end else begin
            position_q = c.position_value;
        end
        r.coil_drive = coils_q;
        r.moving     = (steps_pending != 0) || (now_us < deadline_us);
        r.steps_left = steps_pending;
        r.position   = position_q;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on %s at %0t: expected %h, got %h", field, $realtime,
                         want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_q        = MODE_HALF;
            min_step_q    = MIN_STEP_RESET;
            now_us        = '0;
            move_begin_us = '0;
            move_span_us  = '0;
            deadline_us   = '0;
            steps_pending = '0;
            phase_q       = '0;
            clockwise_q   = 1'b0;
            position_q    = '0;
            coils_q       = '0;
            errors        = 0;
            coil_status_queue.delete();
            mismatch_total    <= 0;
            open_expectations <= 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_STEP_MODE: mode_q     = cfg_data[MODE_W-1:0];
                    REG_MIN_STEP:  min_step_q = cfg_data[MIN_W-1:0];
                    default:       ;
                endcase
            end
            // older result first, then the new command transaction
            if (res_valid && res_ready) begin
                if (coil_status_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result at %0t: %h", $realtime, res_data);
                end else begin
                    oldest = coil_status_queue.pop_front();
                    check_field("coil_drive", 32'(oldest.coil_drive),
                                32'(res_data.coil_drive));
                    check_field("moving", 32'(oldest.moving), 32'(res_data.moving));
                    check_field("steps_left", 32'(oldest.steps_left),
                                32'(res_data.steps_left));
                    check_field("position", 32'(oldest.position), 32'(res_data.position));
                end
            end
            if (cmd_valid && cmd_ready) begin
                advance_sequencer(cmd_data, predicted);
                coil_status_queue.push_back(predicted);
            end
            mismatch_total    <= errors;
            open_expectations <= coil_status_queue.size();
        end
    end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// top of the stepper move sequencer testbench: clock, reset, register writes and command
// stimulus, result back-pressure and the verdict; needs usms_pkg, usms_motion_checker, the core
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import usms_pkg::*;

    // step mode code that the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // cycles granted after the last result before touching the registers
    localparam int SETTLE_CYCLES = 40;
    // length of the deliberate result hold-off
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE  = 567;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_ready;
    usms_in_t               cmd_data = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    usms_out_t              res_data;

    int mismatch_total;
    int open_expectations;

    // idle percentages of the two sides, set per phase by the stimulus
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    // long result hold-offs asked for by the stimulus and started by the receiver
    int   hold_requests = 0;
    int   holds_served = 0;
    int   hold_left = 0;

    // bookkeeping for the closing summary
    int sent_by_kind[4];
    int settings_applied = 0;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    unipolar_stepper_move_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    usms_motion_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .cmd_data          (cmd_data),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .res_data          (res_data),
        .mismatch_total    (mismatch_total),
        .open_expectations (open_expectations)
    );

    // result side: random back-pressure, plus one long hold-off counted here
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            hold_left    = LONG_HOLD_CYCLES;
            holds_served = hold_requests;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic usms_in_t make_cmd(input usms_cmd_t kind, input logic cw,
                                          input logic [STEPS_W-1:0] steps,
                                          input logic [STEPS_W-1:0] target,
                                          input logic [POS_W-1:0] pos);
        usms_in_t c;
        c.command        = kind;
        c.turn_clockwise = cw;
        c.move_steps     = steps;
        c.target_step_us = target;
        c.position_value = pos;
        return c;
    endfunction

    // random command: mostly ticks and short well-formed moves, with a share of
    // full-range moves, stops and position loads; unused fields carry noise
    function automatic usms_in_t random_command();
        usms_in_t c;
        int       pick;
        c.turn_clockwise = 1'($urandom);
        c.move_steps     = STEPS_W'($urandom);
        c.target_step_us = STEPS_W'($urandom);
        c.position_value = $urandom;
        pick = $urandom_range(99);
        if (pick < 68)
            c.command = CMD_TICK;
        else if (pick < 82)
        begin
            c.command = CMD_START;
            if ($urandom_range(9) != 0)
            begin
                c.move_steps     = STEPS_W'($urandom_range(1, 40));
                c.target_step_us = STEPS_W'($urandom_range(0, 12));
            end
            else if ($urandom_range(3) == 0)
                c.move_steps = '0;
        end
        else if (pick < 90)
            c.command = CMD_STOP;
        else
        begin
            c.command = CMD_LOAD;
            case ($urandom_range(7))
                0:       c.position_value = 32'h7FFF_FFFF;
                1:       c.position_value = 32'h8000_0000;
                2:       c.position_value = 32'hFFFF_FFFF;
                default: ;
            endcase
        end
        return c;
    endfunction

    // one command transaction; valid is held with the payload until accepted
    task automatic send_cmd(input usms_in_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        sent_by_kind[c.command]++;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (open_expectations != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers back to back, only while the block is idle
    task automatic program_regs(input logic [MODE_W-1:0] mode, input logic [MIN_W-1:0] min_us);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_STEP_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_index <= REG_MIN_STEP;
        cfg_data  <= min_us;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // random setting: short periods most of the time so moves really step
    task automatic program_random_regs();
        logic [MODE_W-1:0] mode;
        logic [MIN_W-1:0]  min_us;
        mode = ($urandom_range(9) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
        case ($urandom_range(19))
            0:       min_us = 16'd0;
            1:       min_us = 16'd65535;
            2:       min_us = 16'd1000;
            3:       min_us = 16'd2000;
            default: min_us = MIN_W'($urandom_range(1, 6));
        endcase
        program_regs(mode, min_us);
    endtask

    // one idling phase of random traffic, reprogrammed every block of items
    task automatic random_phase(input int sender_pct, input int receiver_pct,
                                input bit with_long_hold);
        int sent;
        int block;
        sent = 0;
        while (sent < ITEMS_PER_PHASE)
        begin
            program_random_regs();
            send_idle_pct = sender_pct;
            recv_idle_pct = receiver_pct;
            block = $urandom_range(60, 120);
            if (block > ITEMS_PER_PHASE - sent)
                block = ITEMS_PER_PHASE - sent;
            repeat (block)
            begin
                // the hold-off lands mid-block so the sender keeps pushing into it
                if (with_long_hold && sent == 40)
                    hold_requests++;
                send_cmd(random_command());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting, half step, 1000 us floor
        send_cmd(make_cmd(CMD_LOAD, 1'b0, '0, '0, 32'h7FFF_FFFF));
        // longest move at the longest period: duration saturates
        send_cmd(make_cmd(CMD_START, 1'b1, 24'hFF_FFFF, 24'hFF_FFFF, '0));
        send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, 1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(make_cmd(CMD_STOP, 1'b1, '0, '0, '0));
        // start with zero steps behaves as stop
        send_cmd(make_cmd(CMD_START, 1'b1, '0, 24'd5, '0));

        // half step with a one-microsecond floor: one step per tick
        program_regs(MODE_HALF, 16'd1);
        send_cmd(make_cmd(CMD_START, 1'b1, 24'd6, '0, '0));
        repeat (5) send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));

        // full step entered with the phase past the 4-phase range, zero floor
        program_regs(MODE_FULL, 16'd0);
        send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));
        send_cmd(make_cmd(CMD_LOAD, 1'b0, '0, '0, 32'h8000_0000));
        // counter-clockwise across the negative wrap
        send_cmd(make_cmd(CMD_START, 1'b0, 24'd3, 24'd2, '0));
        repeat (3) send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));

        // wave step with the largest floor: second tick cannot step
        program_regs(MODE_WAVE, 16'd65535);
        send_cmd(make_cmd(CMD_START, 1'b0, 24'd2, 24'd5, '0));
        send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));
        send_cmd(make_cmd(CMD_STOP, 1'b0, '0, '0, '0));

        // unused mode: coils hold, phase still counts
        program_regs(MODE_UNUSED, 16'd1);
        send_cmd(make_cmd(CMD_START, 1'b1, 24'd2, 24'd1, '0));
        send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, 1'b0, '0, '0, '0));

        // random traffic under three idling patterns, the last with the long hold-off
        random_phase(38, 83, 1'b0);
        random_phase(83, 38, 1'b0);
        random_phase(0, 0, 1'b1);

        // drain: nothing outstanding, then a margin for stray results
        wait_idle();
        repeat (60) @(posedge clk);

        $display("covered %0d ticks, %0d starts, %0d stops, %0d loads over %0d register settings",
                 sent_by_kind[CMD_TICK], sent_by_kind[CMD_START], sent_by_kind[CMD_STOP],
                 sent_by_kind[CMD_LOAD], settings_applied);
        $display("with both sides idling in turn and one %0d-cycle result hold-off",
                 LONG_HOLD_CYCLES);
        if (mismatch_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("watchdog expired with %0d results outstanding", open_expectations);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
